/* src/triangle_table_nearest_search_top_assert.svh */
// Assertion macros used by the triangle table top RTL.
`ifndef TRIANGLE_TABLE_NEAREST_SEARCH_TOP_ASSERT_SVH
`define TRIANGLE_TABLE_NEAREST_SEARCH_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define TTNS_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TTNS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* src/ttns_pkg.sv */
// -----------------------------------------------------------------------------
// ttns_pkg
// Types, constants and helpers for the triangle table search.
// -----------------------------------------------------------------------------
package ttns_pkg;
  localparam int TableDepth = 64;
  localparam int CoordWidth = 24;
  localparam int IndexWidth = 16;
  localparam int SlotWidth  = 6;
  localparam int CntWidth   = 7;
  localparam int SumWidth   = CoordWidth + 2;
  localparam int DiffWidth  = CoordWidth + 4;
  localparam int SqWidth    = 2 * DiffWidth;
  localparam int DistWidth  = SqWidth + 2;

  typedef enum logic [2:0] {
    MODE_STAGE   = 3'd0,
    MODE_COMMIT  = 3'd1,
    MODE_NEAREST = 3'd2,
    MODE_NORMAL  = 3'd3,
    MODE_COLOR   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_NORMAL_TOL = 1'd0,
    REG_COLOR_TOL  = 1'd1
  } reg_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN
  } fsm_e;

  localparam logic [14:0] NormalTolReset = 15'd164;
  localparam logic [17:0] ColorTolReset  = 18'd163;
  localparam logic signed [15:0] NormalOne = 16'sd16384;

  typedef struct packed {
    logic [2:0]            mode;
    logic [1:0]            corner;
    logic signed [23:0]    x;
    logic signed [23:0]    y;
    logic signed [23:0]    z;
    logic [15:0]           index_a;
    logic [15:0]           index_b;
    logic [15:0]           index_c;
    logic [7:0]            color_r;
    logic [7:0]            color_g;
    logic [7:0]            color_b;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [15:0] vertex_index_a;
    logic [15:0] vertex_index_b;
    logic [15:0] vertex_index_c;
    logic        last;
  } rsp_t;

  // One table entry as held in a cell.
  typedef struct packed {
    logic signed [SumWidth-1:0] sx;
    logic signed [SumWidth-1:0] sy;
    logic signed [SumWidth-1:0] sz;
    logic signed [15:0]         nx;
    logic signed [15:0]         ny;
    logic signed [15:0]         nz;
    logic [7:0]                 cr;
    logic [7:0]                 cg;
    logic [7:0]                 cb;
    logic [IndexWidth-1:0]      ia;
    logic [IndexWidth-1:0]      ib;
    logic [IndexWidth-1:0]      ic;
  } entry_t;

  // Query broadcast to the cells.
  typedef struct packed {
    logic [2:0]                  mode;
    logic signed [CoordWidth+1:0] qx;
    logic signed [CoordWidth+1:0] qy;
    logic signed [CoordWidth+1:0] qz;
    logic signed [CoordWidth-1:0] nx;
    logic signed [CoordWidth-1:0] ny;
    logic signed [CoordWidth-1:0] nz;
    logic [7:0]                  cr;
    logic [7:0]                  cg;
    logic [7:0]                  cb;
    logic [14:0]                 ntol;
    logic [17:0]                 ctol;
  } query_t;

  // Token that rotates through the ring of cells.
  typedef struct packed {
    logic                  valid;
    logic [SlotWidth-1:0]  slot;
    entry_t                ent;
  } tok_t;

  function automatic logic signed [15:0] sat16(input logic signed [CoordWidth-1:0] v);
    logic signed [15:0] r;
    if (v > CoordWidth'(32767))       r = 16'sh7fff;
    else if (v < -CoordWidth'(32768)) r = 16'sh8000;
    else                              r = v[15:0];
    return r;
  endfunction
endpackage

/* src/triangle_table_nearest_search_top.sv */
// -----------------------------------------------------------------------------
// triangle_table_nearest_search_top
// Triangle table with nearest-center, normal and color match search.
// -----------------------------------------------------------------------------
// Issue one transaction with start while busy is low. A corner stage finishes in
// the accept cycle and gives no result, and so do unused modes. A commit or any
// query keeps busy high whatever the fill level: a scan, in which the ring of 64
// cells rotates one slot per cycle and comes back to its resting order, then a
// drain that covers the evaluation pipeline. The final result (last set) shows
// on rsp_o with valid_o in the cycle in which busy falls. Match queries send
// every match but the final one during the scan and drain, one per cycle while
// the matching slots are adjacent, so up to 64 results for one transaction. The
// receiver cannot stall: each result is valid for exactly one cycle.
`include "triangle_table_nearest_search_top_assert.svh"
module triangle_table_nearest_search_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ttns_pkg::req_t    req_i,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [17:0]       cfg_data_i,
  output logic              valid_o,
  output ttns_pkg::rsp_t    rsp_o
);
  localparam int N = ttns_pkg::TableDepth;

  ttns_pkg::fsm_e          state_q, state_d;
  logic [14:0]             ntol_q;
  logic [17:0]             ctol_q;
  logic signed [23:0]      stg_q [9];
  logic [3:0]              stg_base;
  logic [ttns_pkg::CntWidth-1:0] count_q, count_d;
  logic [6:0]              step_q, step_d;   // rotation steps done
  ttns_pkg::query_t        qry_q;
  ttns_pkg::tok_t          ring [N+1];
  ttns_pkg::tok_t          feed;
  ttns_pkg::tok_t          ev_tok;
  logic                    shift;
  logic                    accept;
  logic                    is_query;
  logic                    is_match;
  logic                    ev_vld, ev_hit, ev_blk;
  logic [5:0]              ev_slot;
  logic [47:0]             ev_idx;
  logic [ttns_pkg::DistWidth-1:0] ev_dist;
  // Best-so-far for nearest, pending match for match queries.
  logic [ttns_pkg::DistWidth-1:0] best_d_q;
  logic [5:0]              best_s_q;
  logic [47:0]             best_i_q;
  logic                    have_q, have_d;
  logic                    any_q, any_d;
  logic                    valid_d;
  logic                    ins_q;            // empty nearest: default entry pending
  logic                    done;
  logic                    commit_ok;
  logic                    ev_live;
  logic                    ev_take;
  logic                    match_hit;
  ttns_pkg::entry_t        new_ent;
  ttns_pkg::entry_t        dflt_ent;

  assign accept = start && !busy;
  assign busy   = state_q != ttns_pkg::FSM_IDLE;

  assign is_query = qry_q.mode == ttns_pkg::MODE_NEAREST ||
                    qry_q.mode == ttns_pkg::MODE_NORMAL ||
                    qry_q.mode == ttns_pkg::MODE_COLOR;
  assign is_match = qry_q.mode == ttns_pkg::MODE_NORMAL ||
                    qry_q.mode == ttns_pkg::MODE_COLOR;

  // Ring: cell 0 takes from the feed, last cell feeds back.
  assign shift = state_q == ttns_pkg::FSM_SCAN && step_q < 7'(N);

  // At rest the last cell holds slot 0, so the token leaving the ring at step s
  // is slot s. A full scan is exactly N shifts, which restores that order.
  always_comb begin
    feed      = ring[N];
    feed.slot = step_q[5:0];
    if (commit_ok && step_q[5:0] == count_q[5:0]) begin
      // commit: the new entry takes the place of its slot as it wraps
      feed.valid = 1'b1;
      feed.ent   = new_ent;
    end else if (ins_q && step_q == '0) begin
      feed.valid = 1'b1;
      feed.ent   = dflt_ent;
    end
  end
  assign ring[0] = feed;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      ttns_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift),
        .tok_i  (ring[g]),
        .tok_o  (ring[g+1])
      );
    end
  endgenerate

  // The evaluator sees the token as it enters cell 0, after any insertion.
  assign ev_tok = (shift && is_query) ? feed : '0;

  ttns_eval u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .qry_i  (qry_q),
    .tok_i  (ev_tok),
    .vld_o  (ev_vld),
    .slot_o (ev_slot),
    .idx_o  (ev_idx),
    .hit_o  (ev_hit),
    .black_o(ev_blk),
    .dist_o (ev_dist)
  );

  assign commit_ok = qry_q.mode == ttns_pkg::MODE_COMMIT && count_q < 7'(N);

  always_comb begin
    new_ent.sx = ttns_pkg::SumWidth'(stg_q[0]) + ttns_pkg::SumWidth'(stg_q[3]) +
                 ttns_pkg::SumWidth'(stg_q[6]);
    new_ent.sy = ttns_pkg::SumWidth'(stg_q[1]) + ttns_pkg::SumWidth'(stg_q[4]) +
                 ttns_pkg::SumWidth'(stg_q[7]);
    new_ent.sz = ttns_pkg::SumWidth'(stg_q[2]) + ttns_pkg::SumWidth'(stg_q[5]) +
                 ttns_pkg::SumWidth'(stg_q[8]);
    new_ent.nx = ttns_pkg::sat16(qry_q.nx);
    new_ent.ny = ttns_pkg::sat16(qry_q.ny);
    new_ent.nz = ttns_pkg::sat16(qry_q.nz);
    new_ent.cr = qry_q.cr;
    new_ent.cg = qry_q.cg;
    new_ent.cb = qry_q.cb;
    new_ent.ia = best_i_q[47:32];
    new_ent.ib = best_i_q[31:16];
    new_ent.ic = best_i_q[15:0];
  end

  // Default triangle: at the origin, normal +z, black, indices 0,1,2.
  always_comb begin
    dflt_ent    = '0;
    dflt_ent.nz = ttns_pkg::NormalOne;
    dflt_ent.ib = ttns_pkg::IndexWidth'(1);
    dflt_ent.ic = ttns_pkg::IndexWidth'(2);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttns_pkg::FSM_IDLE: begin
        if (accept && (req_i.mode == ttns_pkg::MODE_COMMIT ||
                       req_i.mode == ttns_pkg::MODE_NEAREST ||
                       req_i.mode == ttns_pkg::MODE_NORMAL ||
                       req_i.mode == ttns_pkg::MODE_COLOR)) begin
          state_d = ttns_pkg::FSM_SCAN;
        end
      end
      ttns_pkg::FSM_SCAN:  if (step_q == 7'(N)) state_d = ttns_pkg::FSM_DRAIN;
      ttns_pkg::FSM_DRAIN: if (done) state_d = ttns_pkg::FSM_IDLE;
      default:             state_d = ttns_pkg::FSM_IDLE;
    endcase
  end

  // The drain ends once the last token has left the pipeline and step_q[1:0] reaches 3.
  assign done = state_q == ttns_pkg::FSM_DRAIN && !ev_vld && step_q[1:0] == 2'd3;

  always_comb begin
    step_d = step_q;
    unique case (state_q)
      ttns_pkg::FSM_IDLE:  step_d = '0;
      ttns_pkg::FSM_SCAN:  step_d = (step_q == 7'(N)) ? 7'd0 : step_q + 7'd1;
      ttns_pkg::FSM_DRAIN: step_d = step_q + 7'd1;
      default:             step_d = '0;
    endcase
  end

  // Only entries below the fill count take part.
  assign ev_live   = ev_vld && ({1'b0, ev_slot} < count_q);
  assign ev_take   = ev_live && (ev_slot == 6'd0 || !ev_blk) &&
                     (!have_q || ev_dist < best_d_q || (ev_slot == 6'd0));
  assign match_hit = is_match && ev_live && ev_hit;

  always_comb begin
    count_d = count_q;
    if (accept && req_i.mode == ttns_pkg::MODE_NEAREST && count_q == '0) begin
      // empty nearest: the default triangle fills slot 0
      count_d = 7'd1;
    end else if (done && commit_ok) begin
      count_d = count_q + 7'd1;
    end
  end

  always_comb begin
    have_d  = have_q;
    any_d   = any_q;
    valid_d = done;
    if (accept) begin
      have_d = 1'b0;
      any_d  = 1'b0;
    end else if (qry_q.mode == ttns_pkg::MODE_NEAREST && ev_take) begin
      have_d = 1'b1;
    end else if (match_hit) begin
      have_d = 1'b1;
      any_d  = 1'b1;
      // a new match releases the pending one
      valid_d = have_q;
    end
  end

  assign stg_base = {1'b0, req_i.corner, 1'b0} + {2'b0, req_i.corner};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttns_pkg::FSM_IDLE;
      ntol_q  <= ttns_pkg::NormalTolReset;
      ctol_q  <= ttns_pkg::ColorTolReset;
      count_q <= '0;
      step_q  <= '0;
      have_q  <= 1'b0;
      any_q   <= 1'b0;
      ins_q   <= 1'b0;
      valid_o <= 1'b0;
      for (int i = 0; i < 9; i++) stg_q[i] <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      have_q  <= have_d;
      any_q   <= any_d;
      valid_o <= valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ttns_pkg::REG_NORMAL_TOL: ntol_q <= cfg_data_i[14:0];
          ttns_pkg::REG_COLOR_TOL:  ctol_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && req_i.mode == ttns_pkg::MODE_STAGE && req_i.corner != 2'd3) begin
        stg_q[stg_base]        <= req_i.x;
        stg_q[stg_base + 4'd1] <= req_i.y;
        stg_q[stg_base + 4'd2] <= req_i.z;
      end
      if (accept) begin
        ins_q <= req_i.mode == ttns_pkg::MODE_NEAREST && count_q == '0;
      end
    end
  end

  // Payload: a match is held until the next one arrives so the final one can carry last.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qry_q.mode <= req_i.mode;
      qry_q.qx   <= 26'(req_i.x) + 26'(req_i.x) + 26'(req_i.x);
      qry_q.qy   <= 26'(req_i.y) + 26'(req_i.y) + 26'(req_i.y);
      qry_q.qz   <= 26'(req_i.z) + 26'(req_i.z) + 26'(req_i.z);
      qry_q.nx   <= req_i.x;
      qry_q.ny   <= req_i.y;
      qry_q.nz   <= req_i.z;
      qry_q.cr   <= req_i.color_r;
      qry_q.cg   <= req_i.color_g;
      qry_q.cb   <= req_i.color_b;
      qry_q.ntol <= ntol_q;
      qry_q.ctol <= ctol_q;
      best_i_q   <= {req_i.index_a, req_i.index_b, req_i.index_c};
    end else if (qry_q.mode == ttns_pkg::MODE_NEAREST && ev_take) begin
      best_d_q <= ev_dist;
      best_s_q <= ev_slot;
      best_i_q <= ev_idx;
    end else if (match_hit) begin
      best_s_q <= ev_slot;
      best_i_q <= ev_idx;
    end
    if (match_hit && have_q) begin
      rsp_o <= {ttns_pkg::ST_OK, best_s_q, best_i_q, 1'b0};
    end else if (done) begin
      unique case (qry_q.mode)
        ttns_pkg::MODE_COMMIT:
          rsp_o <= commit_ok ? {ttns_pkg::ST_OK, count_q[5:0], best_i_q, 1'b1}
                             : {ttns_pkg::ST_FULL, 6'd0, 48'd0, 1'b1};
        ttns_pkg::MODE_NEAREST:
          rsp_o <= {ttns_pkg::ST_OK, best_s_q, best_i_q, 1'b1};
        default:
          rsp_o <= any_q ? {ttns_pkg::ST_OK, best_s_q, best_i_q, 1'b1}
                         : {ttns_pkg::ST_NOMATCH, 6'd0, 48'd0, 1'b1};
      endcase
    end
  end

  `TTNS_ASSERT_IMP(a_busy_no_accept, busy, !accept)
  `TTNS_ASSERT_NEXT(a_count_bound, 1'b1, count_q <= 7'(N))
  `TTNS_ASSERT_IMP(a_shift_scan, shift, state_q == ttns_pkg::FSM_SCAN)
endmodule

/* src/ttns_cell.sv */
// -----------------------------------------------------------------------------
// ttns_cell
// One table slot; passes its held entry to the next cell in every cycle with shift_i set.
// -----------------------------------------------------------------------------
module ttns_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  ttns_pkg::tok_t  tok_i,
  output ttns_pkg::tok_t  tok_o
);
  ttns_pkg::tok_t tok_q;
  logic           vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tok_q <= tok_i;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = vld_q;
  end
endmodule

/* src/ttns_eval.sv */
// -----------------------------------------------------------------------------
// ttns_eval
// Two-stage evaluation of the token leaving the ring against the query.
// -----------------------------------------------------------------------------
module ttns_eval (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttns_pkg::query_t  qry_i,
  input  ttns_pkg::tok_t    tok_i,
  output logic              vld_o,
  output logic [5:0]        slot_o,
  output logic [47:0]       idx_o,
  output logic              hit_o,
  output logic              black_o,
  output logic [ttns_pkg::DistWidth-1:0] dist_o
);
  localparam int DW = ttns_pkg::DiffWidth;
  localparam int SW = ttns_pkg::SqWidth;

  logic signed [DW-1:0] dx, dy, dz;
  logic [DW-1:0]        ax_d, ay_d, az_d, ax_q, ay_q, az_q;
  logic                 v1_q, hit1_q, blk1_q;
  logic [5:0]           slot1_q;
  logic [47:0]          idx1_q;
  logic                 nhit, chit;
  logic signed [ttns_pkg::CoordWidth:0] ndx, ndy, ndz;
  logic signed [9:0]    dr, dg, db;
  logic [19:0]          csq;
  logic [SW-1:0]        sx, sy, sz;

  always_comb begin
    dx = DW'(tok_i.ent.sx) - DW'(qry_i.qx);
    dy = DW'(tok_i.ent.sy) - DW'(qry_i.qy);
    dz = DW'(tok_i.ent.sz) - DW'(qry_i.qz);
    ax_d = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ay_d = dy[DW-1] ? DW'(-dy) : DW'(dy);
    az_d = dz[DW-1] ? DW'(-dz) : DW'(dz);
    ndx = (ttns_pkg::CoordWidth+1)'(qry_i.nx) - (ttns_pkg::CoordWidth+1)'(tok_i.ent.nx);
    ndy = (ttns_pkg::CoordWidth+1)'(qry_i.ny) - (ttns_pkg::CoordWidth+1)'(tok_i.ent.ny);
    ndz = (ttns_pkg::CoordWidth+1)'(qry_i.nz) - (ttns_pkg::CoordWidth+1)'(tok_i.ent.nz);
    nhit = (ndx <= $signed({1'b0, qry_i.ntol})) && (ndx >= -$signed({1'b0, qry_i.ntol})) &&
           (ndy <= $signed({1'b0, qry_i.ntol})) && (ndy >= -$signed({1'b0, qry_i.ntol})) &&
           (ndz <= $signed({1'b0, qry_i.ntol})) && (ndz >= -$signed({1'b0, qry_i.ntol}));
    dr = $signed({2'b0, tok_i.ent.cr}) - $signed({2'b0, qry_i.cr});
    dg = $signed({2'b0, tok_i.ent.cg}) - $signed({2'b0, qry_i.cg});
    db = $signed({2'b0, tok_i.ent.cb}) - $signed({2'b0, qry_i.cb});
    csq = 20'(dr * dr) + 20'(dg * dg) + 20'(db * db);
    chit = csq < {2'b0, qry_i.ctol};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      vld_o <= 1'b0;
    end else begin
      v1_q  <= tok_i.valid;
      vld_o <= v1_q;
    end
  end

  // Squares are the multipliers; 28x28 each, one per coordinate.
  always_comb begin
    sx = SW'(ax_q) * SW'(ax_q);
    sy = SW'(ay_q) * SW'(ay_q);
    sz = SW'(az_q) * SW'(az_q);
  end

  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    az_q    <= az_d;
    hit1_q  <= (qry_i.mode == ttns_pkg::MODE_NORMAL) ? nhit : chit;
    blk1_q  <= (tok_i.ent.cr | tok_i.ent.cg | tok_i.ent.cb) == 8'd0;
    slot1_q <= tok_i.slot;
    idx1_q  <= {tok_i.ent.ia, tok_i.ent.ib, tok_i.ent.ic};
    slot_o  <= slot1_q;
    idx_o   <= idx1_q;
    hit_o   <= hit1_q;
    black_o <= blk1_q;
    dist_o  <= ttns_pkg::DistWidth'(sx) + ttns_pkg::DistWidth'(sy) +
               ttns_pkg::DistWidth'(sz);
  end
endmodule

/* verif/tb_triangle_table_nearest_search_top.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_triangle_table_nearest_search_top
// Self-checking bench for the triangle table search: a directed table of
// transactions, then random load sequences and queries under several tolerance
// settings. A predictor mirrors the table and every result is checked in order.
// -----------------------------------------------------------------------------
module tb_triangle_table_nearest_search_top;
  import ttns_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [17:0] cfg_data_i;
  logic        valid_o;
  rsp_t        rsp_o;

  triangle_table_nearest_search_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .valid_o   (valid_o),
    .rsp_o     (rsp_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3ms;
    $display("tb_triangle_table_nearest_search_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predicted table contents and tolerances
  // ---------------------------------------------------------------------------
  longint          staged_pos [9];
  longint          tri_sum [64][3];
  int              tri_nrm [64][3];
  int              tri_rgb [64][3];
  logic [15:0]     tri_idx [64][3];
  int              tri_count;
  int unsigned     nrm_tol;
  int unsigned     rgb_tol_sq;

  rsp_t            expected_rsp[$];
  int              errors;

  // Append one expectation at the tail of the queue.
  function automatic void queue_rsp(input rsp_t r);
    expected_rsp.insert(expected_rsp.size(), r);
  endfunction

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic rsp_t make_rsp(status_e st, int slot, logic last);
    rsp_t r;
    r = '0;
    r.status = st;
    r.slot   = slot[5:0];
    if (st == ST_OK) begin
      r.vertex_index_a = tri_idx[slot][0];
      r.vertex_index_b = tri_idx[slot][1];
      r.vertex_index_c = tri_idx[slot][2];
    end
    r.last = last;
    return r;
  endfunction

  function automatic longint unsigned center_dist(int s, longint qx, longint qy, longint qz);
    longint dx, dy, dz;
    dx = tri_sum[s][0] - 3 * qx;
    dy = tri_sum[s][1] - 3 * qy;
    dz = tri_sum[s][2] - 3 * qz;
    return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
  endfunction

  // Update the predicted table for one accepted transaction and queue its results.
  task automatic predict_table_rsp(input req_t rq);
    longint           qx, qy, qz;
    longint unsigned  best_d, d;
    int               best, hits, dr, dg, db;
    bit               hit;
    rsp_t             r;
    qx = longint'(rq.x);
    qy = longint'(rq.y);
    qz = longint'(rq.z);
    case (rq.mode)
      MODE_STAGE: begin
        if (rq.corner < 3) begin
          staged_pos[rq.corner*3]   = qx;
          staged_pos[rq.corner*3+1] = qy;
          staged_pos[rq.corner*3+2] = qz;
        end
      end
      MODE_COMMIT: begin
        if (tri_count >= 64) begin
          queue_rsp(make_rsp(ST_FULL, 0, 1'b1));
        end else begin
          for (int a = 0; a < 3; a++)
            tri_sum[tri_count][a] = staged_pos[a] + staged_pos[a+3] + staged_pos[a+6];
          tri_nrm[tri_count] = '{clamp16(qx), clamp16(qy), clamp16(qz)};
          tri_rgb[tri_count] = '{rq.color_r, rq.color_g, rq.color_b};
          tri_idx[tri_count] = '{rq.index_a, rq.index_b, rq.index_c};
          queue_rsp(make_rsp(ST_OK, tri_count, 1'b1));
          tri_count++;
        end
      end
      MODE_NEAREST: begin
        if (tri_count == 0) begin
          tri_sum[0] = '{0, 0, 0};
          tri_nrm[0] = '{0, 0, 16384};
          tri_rgb[0] = '{0, 0, 0};
          tri_idx[0] = '{16'd0, 16'd1, 16'd2};
          tri_count  = 1;
        end
        best   = 0;
        best_d = center_dist(0, qx, qy, qz);
        for (int s = 1; s < tri_count; s++) begin
          // black entries past the first never win
          if ((tri_rgb[s][0] | tri_rgb[s][1] | tri_rgb[s][2]) == 0) continue;
          d = center_dist(s, qx, qy, qz);
          if (d < best_d) begin
            best_d = d;
            best   = s;
          end
        end
        queue_rsp(make_rsp(ST_OK, best, 1'b1));
      end
      MODE_NORMAL, MODE_COLOR: begin
        hits = 0;
        for (int s = 0; s < tri_count; s++) begin
          if (rq.mode == MODE_NORMAL) begin
            hit = 1'b1;
            for (int a = 0; a < 3; a++) begin
              if ((a == 0 ? qx : a == 1 ? qy : qz) - tri_nrm[s][a] > longint'(nrm_tol) ||
                  tri_nrm[s][a] - (a == 0 ? qx : a == 1 ? qy : qz) > longint'(nrm_tol))
                hit = 1'b0;
            end
          end else begin
            dr  = tri_rgb[s][0] - rq.color_r;
            dg  = tri_rgb[s][1] - rq.color_g;
            db  = tri_rgb[s][2] - rq.color_b;
            hit = (dr*dr + dg*dg + db*db) < rgb_tol_sq;
          end
          if (hit) begin
            queue_rsp(make_rsp(ST_OK, s, 1'b0));
            hits++;
          end
        end
        if (hits == 0) begin
          queue_rsp(make_rsp(ST_NOMATCH, 0, 1'b1));
        end else begin
          r = expected_rsp.pop_back();
          r.last = 1'b1;
          queue_rsp(r);
        end
      end
      default: ;  // unused modes: ignored
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is compared against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && valid_o) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result %p", $time, rsp_o);
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp_o.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.slot !== e.slot) begin
          $display("%0t: slot exp %0d got %0d", $time, e.slot, rsp_o.slot);
          errors++;
        end
        if (rsp_o.vertex_index_a !== e.vertex_index_a) begin
          $display("%0t: index_a exp %h got %h", $time, e.vertex_index_a, rsp_o.vertex_index_a);
          errors++;
        end
        if (rsp_o.vertex_index_b !== e.vertex_index_b) begin
          $display("%0t: index_b exp %h got %h", $time, e.vertex_index_b, rsp_o.vertex_index_b);
          errors++;
        end
        if (rsp_o.vertex_index_c !== e.vertex_index_c) begin
          $display("%0t: index_c exp %h got %h", $time, e.vertex_index_c, rsp_o.vertex_index_c);
          errors++;
        end
        if (rsp_o.last !== e.last) begin
          $display("%0t: last exp %0b got %0b", $time, e.last, rsp_o.last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of back-to-back transactions with random gaps
  // ---------------------------------------------------------------------------
  int burst_left;

  task automatic send_txn(input req_t rq, input bit has_typed, input rsp_t typed);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    // accepted at this edge
    if (has_typed) begin
      predict_table_rsp(rq);
      void'(expected_rsp.pop_back());
      queue_rsp(typed);
    end else begin
      predict_table_rsp(rq);
    end
  endtask

  // Wait until every result is in and the block has had time to settle.
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp.size() != 0 || busy) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_tol(input reg_e idx, input logic [17:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_NORMAL_TOL) nrm_tol = val[14:0];
    else rgb_tol_sq = val;
  endtask

  function automatic req_t mk(mode_e m, logic [1:0] c, int x, int y, int z,
                              int ia, int ib, int ic, int r, int g, int b);
    req_t q;
    q = '{m, c, x[23:0], y[23:0], z[23:0], ia[15:0], ib[15:0], ic[15:0],
          r[7:0], g[7:0], b[7:0]};
    return q;
  endfunction

  // Random field helpers
  function automatic int rnd_coord();
    case ($urandom_range(0, 3))
      0: return int'($signed($urandom_range(0, 24'hffffff) << 8)) >>> 8;
      1: return int'($urandom_range(0, 4096)) - 2048;
      2: return $urandom_range(0, 1) ? 8388607 : -8388608;
      default: return (int'($urandom_range(0, 15)) - 8) * 256;
    endcase
  endfunction

  function automatic int rnd_normal_comp(bit major);
    if ($urandom_range(0, 9) < 2) return rnd_coord();
    return (major ? 16384 : 0) + int'($urandom_range(0, 600)) - 300;
  endfunction

  function automatic logic [23:0] rnd_rgb();
    logic [23:0] pal [4] = '{24'hff0000, 24'h00ff00, 24'h2080c0, 24'hffffff};
    logic [23:0] c;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 24'($urandom_range(0, 24'hffffff));
      default: begin
        c = pal[$urandom_range(0, 3)];
        for (int i = 0; i < 3; i++)
          if (c[i*8 +: 8] > 8'd8) c[i*8 +: 8] = c[i*8 +: 8] - 8'($urandom_range(0, 8));
        return c;
      end
    endcase
  endfunction

  // Directed rows: transaction, typed expectation flag, typed expectation
  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t exp;
  } dir_row_t;

  dir_row_t  dir_rows[$];
  int        counted;
  req_t      rq;
  logic [23:0] rgb;
  int        order[3];

  initial begin
    errors     = 0;
    burst_left = 0;
    tri_count  = 0;
    nrm_tol    = NormalTolReset;
    rgb_tol_sq = ColorTolReset;
    foreach (staged_pos[i]) staged_pos[i] = 0;
    start      = 1'b0;
    req_i      = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, extremes, every mode, ignored items
    dir_rows = '{
      '{mk(MODE_NEAREST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
        '{ST_OK, 6'd0, 16'd0, 16'd1, 16'd2, 1'b1}},
      '{mk(MODE_NEAREST, 0, 8388607, -8388608, 8388607, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_STAGE, 0, 8388607, -8388608, 8388607, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_STAGE, 1, 8388607, -8388608, 8388607, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_STAGE, 2, 8388607, -8388608, 8388607, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_COMMIT, 0, 8388607, -8388608, 16384, 65535, 0, 16'h1234, 255, 255, 255), 1,
        '{ST_OK, 6'd1, 16'hffff, 16'd0, 16'h1234, 1'b1}},
      '{mk(MODE_STAGE, 3, 1000, 1000, 1000, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(mode_e'(3'd5), 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(mode_e'(3'd7), 3, -1, -1, -1, 65535, 65535, 65535, 255, 255, 255), 0, '0},
      '{mk(MODE_STAGE, 0, -8388608, 8388607, -8388608, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_STAGE, 1, -8388608, 8388607, -8388608, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_STAGE, 2, -8388608, 8388607, -8388608, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_COMMIT, 0, 0, 0, 16384, 7, 8, 9, 0, 0, 0), 1,
        '{ST_OK, 6'd2, 16'd7, 16'd8, 16'd9, 1'b1}},
      '{mk(MODE_COMMIT, 0, -8388608, 32768, -32769, 65535, 65535, 65535, 1, 0, 0), 0, '0},
      '{mk(MODE_NEAREST, 0, -8388608, 8388607, -8388608, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_NEAREST, 0, 8388607, -8388608, 8388607, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_NORMAL, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_NORMAL, 0, 32767, -32768, -32768, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_NORMAL, 0, -8388608, -8388608, -8388608, 0, 0, 0, 0, 0, 0), 1,
        '{ST_NOMATCH, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
      '{mk(MODE_COLOR, 0, 0, 0, 0, 0, 0, 0, 255, 255, 255), 0, '0},
      '{mk(MODE_COLOR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
      '{mk(MODE_COLOR, 0, 0, 0, 0, 0, 0, 0, 0, 128, 0), 1,
        '{ST_NOMATCH, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1}}
    };
    foreach (dir_rows[i]) send_txn(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].exp);

    // Random part under several tolerance settings, extremes included
    for (int phase = 0; phase < 4; phase++) begin
      wait_quiet();
      case (phase)
        0: begin
          write_tol(REG_NORMAL_TOL, 18'd0);
          write_tol(REG_COLOR_TOL, 18'd0);
        end
        1: begin
          write_tol(REG_NORMAL_TOL, 18'd16384);
          write_tol(REG_COLOR_TOL, 18'd195075);
        end
        2: begin
          write_tol(REG_NORMAL_TOL, 18'h7fff);
          write_tol(REG_COLOR_TOL, 18'h3ffff);
        end
        default: begin
          write_tol(REG_NORMAL_TOL, 18'($urandom_range(50, 800)));
          write_tol(REG_COLOR_TOL, 18'($urandom_range(100, 3000)));
        end
      endcase
      counted = 0;
      while (counted < 36) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // load: three corners in random order, then the commit
            order = '{0, 1, 2};
            order.shuffle();
            foreach (order[k]) begin
              rq = mk(MODE_STAGE, 2'(order[k]), rnd_coord(), rnd_coord(), rnd_coord(),
                      0, 0, 0, 0, 0, 0);
              rq.index_a = 16'($urandom);
              send_txn(rq, 0, '0);
            end
            rgb = rnd_rgb();
            rq  = mk(MODE_COMMIT, 2'($urandom), rnd_normal_comp(0), rnd_normal_comp(0),
                     rnd_normal_comp(1), $urandom, $urandom, $urandom,
                     rgb[23:16], rgb[15:8], rgb[7:0]);
            send_txn(rq, 0, '0);
            counted += 4;
          end
          5, 6: begin
            rq = mk(MODE_NEAREST, 2'($urandom), rnd_coord(), rnd_coord(), rnd_coord(),
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            send_txn(rq, 0, '0);
            counted++;
          end
          7: begin
            rq = mk(MODE_NORMAL, 2'($urandom), rnd_normal_comp(0), rnd_normal_comp(0),
                    rnd_normal_comp(1), $urandom, $urandom, $urandom, $urandom, 0, 0);
            send_txn(rq, 0, '0);
            counted++;
          end
          8: begin
            rgb = rnd_rgb();
            rq  = mk(MODE_COLOR, 2'($urandom), rnd_coord(), 0, 0, 0, 0, 0,
                     rgb[23:16], rgb[15:8], rgb[7:0]);
            send_txn(rq, 0, '0);
            counted++;
          end
          default: begin
            // noise: lone stage, ignored corner or unused mode
            rq = mk(MODE_STAGE, 2'($urandom), $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            rq.mode = $urandom_range(0, 1) ? MODE_STAGE : mode_e'($urandom_range(5, 7));
            send_txn(rq, 0, '0);
          end
        endcase
      end
    end

    wait_quiet();
    if (errors == 0) begin
      $display("tb_triangle_table_nearest_search_top: PASS");
    end else begin
      $display("tb_triangle_table_nearest_search_top: FAIL");
    end
    $finish;
  end

endmodule
